@@ hdl/ebpf_pkg.sv @@
// Shared types and constants for the eBPF instruction executor.
// Used by ebpf_muldiv and ebpf_instruction_executor; no dependencies.
package ebpf_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_EXITED    = 3'd1;
  localparam logic [2:0] ST_UNSUPP    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_STEPLIMIT = 3'd4;

  localparam logic [2:0] CLS_LD    = 3'd0;
  localparam logic [2:0] CLS_LDX   = 3'd1;
  localparam logic [2:0] CLS_ST    = 3'd2;
  localparam logic [2:0] CLS_STX   = 3'd3;
  localparam logic [2:0] CLS_ALU   = 3'd4;
  localparam logic [2:0] CLS_JMP   = 3'd5;
  localparam logic [2:0] CLS_JMP32 = 3'd6;
  localparam logic [2:0] CLS_ALU64 = 3'd7;

  localparam logic [3:0] OP_ADD  = 4'h0;
  localparam logic [3:0] OP_SUB  = 4'h1;
  localparam logic [3:0] OP_MUL  = 4'h2;
  localparam logic [3:0] OP_DIV  = 4'h3;
  localparam logic [3:0] OP_OR   = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LSH  = 4'h6;
  localparam logic [3:0] OP_RSH  = 4'h7;
  localparam logic [3:0] OP_NEG  = 4'h8;
  localparam logic [3:0] OP_MOD  = 4'h9;
  localparam logic [3:0] OP_XOR  = 4'ha;
  localparam logic [3:0] OP_MOV  = 4'hb;
  localparam logic [3:0] OP_ARSH = 4'hc;

  localparam logic [3:0] JOP_JA   = 4'h0;
  localparam logic [3:0] JOP_JEQ  = 4'h1;
  localparam logic [3:0] JOP_JGT  = 4'h2;
  localparam logic [3:0] JOP_JGE  = 4'h3;
  localparam logic [3:0] JOP_JSET = 4'h4;
  localparam logic [3:0] JOP_JNE  = 4'h5;
  localparam logic [3:0] JOP_JSGT = 4'h6;
  localparam logic [3:0] JOP_JSGE = 4'h7;
  localparam logic [3:0] JOP_CALL = 4'h8;
  localparam logic [3:0] JOP_EXIT = 4'h9;
  localparam logic [3:0] JOP_JLT  = 4'ha;
  localparam logic [3:0] JOP_JLE  = 4'hb;
  localparam logic [3:0] JOP_JSLT = 4'hc;
  localparam logic [3:0] JOP_JSLE = 4'hd;

  localparam logic [7:0] OPC_LDDW = 8'h18;
  localparam logic [3:0] NUM_REGS = 4'd11;
  localparam logic [3:0] REG_FP   = 4'd10;
  localparam logic [3:0] REG_R0   = 4'd0;
  localparam logic [3:0] REG_R6   = 4'd6;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  typedef struct packed {
    logic done;
  } md_rsp_t;

  function automatic logic [3:0] access_bytes(input logic [1:0] sz);
    logic [3:0] n;
    case (sz)
      2'b00:   n = 4'd4;
      2'b01:   n = 4'd2;
      2'b10:   n = 4'd1;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] size_mask(input logic [3:0] bytes);
    logic [63:0] m;
    case (bytes)
      4'd1:    m = 64'h0000_0000_0000_00ff;
      4'd2:    m = 64'h0000_0000_0000_ffff;
      4'd4:    m = 64'h0000_0000_ffff_ffff;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/ebpf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ebpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/ebpf_muldiv.sv @@
// Shared multi-cycle unit: 64-bit multiply from three 32x32 partial products
// and a restoring divider that retires one quotient bit per cycle. Uses ebpf_pkg.
module ebpf_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  ebpf_pkg::md_req_t req,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  output ebpf_pkg::md_rsp_t rsp,
  output logic [63:0]      prod,
  output logic [63:0]      quo,
  output logic [63:0]      rem
);
  import ebpf_pkg::*;

  logic        busy_r, busy_nxt;
  logic        div_r, div_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] rm_r, rm_nxt;
  logic [63:0] pp;
  logic [64:0] sh;
  logic [64:0] diff;

  always_comb begin
    // Pick the partial product for this cycle of the multiply.
    case (cnt_r[1:0])
      2'd0:    pp = 64'(a_r[31:0] * b_r[31:0]);
      2'd1:    pp = {32'(a_r[31:0] * b_r[63:32]), 32'd0};
      default: pp = {32'(a_r[63:32] * b_r[31:0]), 32'd0};
    endcase
    sh   = {rm_r, a_r[63]};
    diff = sh - {1'b0, b_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rm_nxt   = rm_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.is_div;
      cnt_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      rm_nxt   = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 7'd1;
      if (div_r) begin
        // In divide mode a_r shifts left and collects the quotient bits.
        if (!diff[64]) begin
          rm_nxt = diff[63:0];
          a_nxt  = {a_r[62:0], 1'b1};
        end else begin
          rm_nxt = sh[63:0];
          a_nxt  = {a_r[62:0], 1'b0};
        end
        if (cnt_r == 7'd63) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else begin
        acc_nxt = acc_r + pp;
        if (cnt_r == 7'd2) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      div_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      div_r  <= div_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rm_r  <= rm_nxt;
  end

  assign rsp.done = done_r;
  assign prod     = acc_r;
  assign quo      = a_r;
  assign rem      = rm_r;

endmodule

@@ hdl/ebpf_instruction_executor.sv @@
// Most items go accept, execute, output; multiply, divide and modulo wait on
// the muldiv unit (one quotient bit per cycle), and a call or a return moves
// r6-r10 and the return pc one word a cycle through the frame RAM port. One
// item is in work at a time, so none is taken until the last is through; the
// next is accepted while the previous result waits. Reset (synchronous, active
// low) clears control state and the register valid bits, so registers read 0.
module ebpf_instruction_executor #(
  parameter int MAX_FRAMES  = 8,
  parameter int STACK_BYTES = 512
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[7:0], dst_index[11:8], src_index[15:12], offset[31:16],
  // immediate[63:32], next_immediate[95:64], entry_or_data[159:96]
  input  logic [159:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pc[63:0], mem_op[65:64], mem_addr[129:66], mem_bytes[133:130],
  // store_data[197:134], status[200:198], exit_value[232:201], zero fill above
  output logic [239:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import ebpf_pkg::*;

  localparam int DW = $clog2(MAX_FRAMES + 1);
  localparam int FA = $clog2(MAX_FRAMES) + 3;
  localparam logic [63:0] SB = 64'(STACK_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MD   = 3'd2;
  localparam logic [2:0] S_CALL = 3'd3;
  localparam logic [2:0] S_RET  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  cmd_r;
  logic [7:0]  opc_r;
  logic [3:0]  di_r, si_r;
  logic [15:0] off_r;
  logic [31:0] imm_r, nimm_r;
  logic [63:0] eod_r;

  logic [63:0] pc_r, pc_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [31:0] steps_r, steps_nxt;
  logic        run_r, run_nxt;
  logic        ldv_r, ldv_nxt;
  logic [3:0]  ldreg_r, ldreg_nxt;
  logic [3:0]  ldbytes_r, ldbytes_nxt;
  logic [2:0]  hstat_r, hstat_nxt;
  logic [31:0] hcode_r, hcode_nxt;
  logic [15:0] valid_r, valid_nxt;
  logic [63:0] base_r;
  logic [31:0] limit_r;

  logic [1:0]  rop_r, rop_nxt;
  logic [63:0] raddr_r, raddr_nxt;
  logic [3:0]  rbytes_r, rbytes_nxt;
  logic [63:0] rdata_r, rdata_nxt;
  logic [2:0]  rstat_r, rstat_nxt;

  logic        ov_r, ov_nxt;
  logic [63:0] opc_out_r, opc_out_nxt;
  logic [1:0]  oop_r, oop_nxt;
  logic [63:0] oaddr_r, oaddr_nxt;
  logic [3:0]  obytes_r, obytes_nxt;
  logic [63:0] odata_r, odata_nxt;
  logic [2:0]  ostat_r, ostat_nxt;
  logic [31:0] ocode_r, ocode_nxt;

  // Register file: two copies written together give two read ports.
  logic        rf_we;
  logic [3:0]  rf_waddr, rf_ra, rf_rb;
  logic [63:0] rf_wdata, rf_da, rf_db;
  logic        va_r, vb_r;
  logic        fm_we;
  logic [FA-1:0] fm_waddr, fm_raddr;
  logic [63:0] fm_wdata, fm_rdata;

  md_req_t     md_req;
  md_rsp_t     md_rsp;
  logic [63:0] md_a, md_b, md_prod, md_quo, md_rem;

  logic        accept;
  logic        in_exit;
  logic        exit_r;
  logic [2:0]  cls;
  logic [3:0]  op;
  logic        xsrc, w64, bad_d, bad_s;
  logic [63:0] rva, rvb, imm_sx, off_sx, sval, dval, alu_res;
  logic [63:0] jd, js, jsb, sd, ss;
  logic        tk;
  logic [3:0]  nb;
  logic [DW-1:0] kdep;

  ebpf_ram #(.WIDTH(64), .DEPTH(16)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_ra), .rdata(rf_da)
  );
  ebpf_ram #(.WIDTH(64), .DEPTH(16)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_rb), .rdata(rf_db)
  );
  ebpf_ram #(.WIDTH(64), .DEPTH(2 ** FA)) u_frame (
    .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(fm_raddr), .rdata(fm_rdata)
  );
  ebpf_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .req(md_req), .a(md_a), .b(md_b),
    .rsp(md_rsp), .prod(md_prod), .quo(md_quo), .rem(md_rem)
  );

  function automatic logic [63:0] alu_f(input logic [3:0] aop, input logic [63:0] d,
                                        input logic [63:0] s, input logic wide);
    logic [63:0] r;
    logic [31:0] d32, s32;
    d32 = d[31:0];
    s32 = s[31:0];
    case (aop)
      OP_ADD:  r = wide ? d + s : 64'(d32 + s32);
      OP_SUB:  r = wide ? d - s : 64'(d32 - s32);
      OP_OR:   r = d | s;
      OP_AND:  r = d & s;
      OP_LSH:  r = wide ? d << s[5:0] : 64'(d32 << s32[4:0]);
      OP_RSH:  r = wide ? d >> s[5:0] : 64'(d32 >> s32[4:0]);
      OP_NEG:  r = wide ? 64'd0 - d : 64'(32'd0 - d32);
      OP_XOR:  r = d ^ s;
      OP_MOV:  r = s;
      OP_ARSH: r = wide ? 64'($signed(d) >>> s[5:0]) : 64'($signed(d32) >>> s32[4:0]);
      default: r = d;
    endcase
    return wide ? r : {32'd0, r[31:0]};
  endfunction

  assign accept  = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE);
  assign in_exit = (in_tdata[2:0] == CLS_JMP || in_tdata[2:0] == CLS_JMP32) &&
                   (in_tdata[7:4] == JOP_EXIT);

  // Read addresses come from the incoming item in idle and from the latched
  // item afterwards; only a call steps it from r6 up, else read data stays put.
  always_comb begin
    if (st_r == S_IDLE) begin
      rf_ra = in_tdata[11:8];
      rf_rb = in_exit ? REG_R0 : in_tdata[15:12];
    end else begin
      rf_ra = (st_r == S_CALL) ? REG_R6 + {1'b0, cnt_r} : di_r;
      rf_rb = exit_r ? REG_R0 : si_r;
    end
  end

  assign cls    = opc_r[2:0];
  assign op     = opc_r[7:4];
  assign xsrc   = opc_r[3];
  assign w64    = (cls == CLS_ALU64);
  assign bad_d  = (di_r >= NUM_REGS);
  assign bad_s  = (si_r >= NUM_REGS);
  assign rva    = va_r ? rf_da : 64'd0;
  assign rvb    = vb_r ? rf_db : 64'd0;
  assign imm_sx = {{32{imm_r[31]}}, imm_r};
  assign off_sx = {{48{off_r[15]}}, off_r};
  assign sval   = xsrc ? rvb : imm_sx;
  assign dval   = rva;
  assign alu_res = alu_f(op, dval, sval, w64);
  assign nb     = access_bytes(opc_r[4:3]);
  assign kdep   = depth_r - DW'(1);

  assign md_a = w64 ? dval : {32'd0, dval[31:0]};
  assign md_b = w64 ? sval : {32'd0, sval[31:0]};

  always_comb begin
    jsb = (cls == CLS_JMP32) ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
    jd  = (cls == CLS_JMP32) ? {32'd0, dval[31:0]} : dval;
    js  = (cls == CLS_JMP32) ? {32'd0, sval[31:0]} : sval;
    sd  = jd ^ jsb;
    ss  = js ^ jsb;
    case (op)
      JOP_JA:   tk = 1'b1;
      JOP_JEQ:  tk = (jd == js);
      JOP_JGT:  tk = (jd > js);
      JOP_JGE:  tk = (jd >= js);
      JOP_JSET: tk = ((jd & js) != 64'd0);
      JOP_JNE:  tk = (jd != js);
      JOP_JSGT: tk = (sd > ss);
      JOP_JSGE: tk = (sd >= ss);
      JOP_JLT:  tk = (jd < js);
      JOP_JLE:  tk = (jd <= js);
      JOP_JSLT: tk = (sd < ss);
      JOP_JSLE: tk = (sd <= ss);
      default:  tk = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    pc_nxt      = pc_r;
    depth_nxt   = depth_r;
    steps_nxt   = steps_r;
    run_nxt     = run_r;
    ldv_nxt     = ldv_r;
    ldreg_nxt   = ldreg_r;
    ldbytes_nxt = ldbytes_r;
    hstat_nxt   = hstat_r;
    hcode_nxt   = hcode_r;
    valid_nxt   = valid_r;
    rop_nxt     = rop_r;
    raddr_nxt   = raddr_r;
    rbytes_nxt  = rbytes_r;
    rdata_nxt   = rdata_r;
    rstat_nxt   = rstat_r;
    rf_we       = 1'b0;
    rf_waddr    = di_r;
    rf_wdata    = alu_res;
    fm_we       = 1'b0;
    fm_waddr    = FA'((32'(kdep) << 3) | 32'(cnt_r - 3'd1));
    fm_wdata    = rva;
    fm_raddr    = FA'((32'(kdep) << 3) | 32'(cnt_r));
    md_req      = '0;
    md_req.is_div = (op != OP_MUL);
    ov_nxt      = ov_r;
    opc_out_nxt = opc_out_r;
    oop_nxt     = oop_r;
    oaddr_nxt   = oaddr_r;
    obytes_nxt  = obytes_r;
    odata_nxt   = odata_r;
    ostat_nxt   = ostat_r;
    ocode_nxt   = ocode_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (accept) begin
          st_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        st_nxt     = S_OUT;
        rop_nxt    = MEM_NONE;
        raddr_nxt  = '0;
        rbytes_nxt = '0;
        rdata_nxt  = '0;
        rstat_nxt  = ST_RUN;
        if (cmd_r == CMD_START) begin
          rf_we     = 1'b1;
          rf_waddr  = REG_FP;
          rf_wdata  = base_r + SB;
          valid_nxt = 16'(1) << REG_FP;
          pc_nxt    = eod_r;
          run_nxt   = 1'b1;
          depth_nxt = '0;
          steps_nxt = '0;
          ldv_nxt   = 1'b0;
          hstat_nxt = ST_RUN;
          hcode_nxt = '0;
        end else if (!run_r || cmd_r == CMD_NONE) begin
          rstat_nxt = run_r ? ST_RUN : hstat_r;
        end else if (cmd_r == CMD_LOAD) begin
          if (ldv_r) begin
            rf_we     = 1'b1;
            rf_waddr  = ldreg_r;
            rf_wdata  = eod_r & size_mask(ldbytes_r);
            valid_nxt = valid_r | (16'(1) << ldreg_r);
            ldv_nxt   = 1'b0;
          end
        end else if (ldv_r) begin
          // An instruction arriving while a load is pending is ignored.
          rstat_nxt = ST_RUN;
        end else if (steps_r >= limit_r) begin
          run_nxt   = 1'b0;
          hstat_nxt = ST_STEPLIMIT;
          rstat_nxt = ST_STEPLIMIT;
        end else begin
          steps_nxt = steps_r + 32'd1;
          case (cls)
            CLS_ALU, CLS_ALU64: begin
              if (bad_d || (xsrc && bad_s)) begin
                run_nxt   = 1'b0;
                hstat_nxt = ST_UNSUPP;
                rstat_nxt = ST_UNSUPP;
              end else if (op == OP_MUL || op == OP_DIV || op == OP_MOD) begin
                md_req.start = 1'b1;
                st_nxt       = S_MD;
              end else begin
                rf_we     = 1'b1;
                valid_nxt = valid_r | (16'(1) << di_r);
                pc_nxt    = pc_r + 64'd8;
              end
            end
            CLS_LDX: begin
              if (bad_d || bad_s) begin
                run_nxt   = 1'b0;
                hstat_nxt = ST_UNSUPP;
                rstat_nxt = ST_UNSUPP;
              end else begin
                ldv_nxt     = 1'b1;
                ldreg_nxt   = di_r;
                ldbytes_nxt = nb;
                pc_nxt      = pc_r + 64'd8;
                rop_nxt     = MEM_READ;
                raddr_nxt   = rvb + off_sx;
                rbytes_nxt  = nb;
              end
            end
            CLS_ST, CLS_STX: begin
              if (bad_d || (cls == CLS_STX && bad_s)) begin
                run_nxt   = 1'b0;
                hstat_nxt = ST_UNSUPP;
                rstat_nxt = ST_UNSUPP;
              end else begin
                pc_nxt     = pc_r + 64'd8;
                rop_nxt    = MEM_WRITE;
                raddr_nxt  = rva + off_sx;
                rbytes_nxt = nb;
                rdata_nxt  = ((cls == CLS_STX) ? rvb : imm_sx) & size_mask(nb);
              end
            end
            CLS_LD: begin
              if (opc_r != OPC_LDDW || bad_d) begin
                run_nxt   = 1'b0;
                hstat_nxt = ST_UNSUPP;
                rstat_nxt = ST_UNSUPP;
              end else begin
                rf_we     = 1'b1;
                rf_wdata  = {nimm_r, imm_r};
                valid_nxt = valid_r | (16'(1) << di_r);
                pc_nxt    = pc_r + 64'd16;
              end
            end
            default: begin
              if (op == JOP_CALL) begin
                if (si_r != 4'd1) begin
                  run_nxt   = 1'b0;
                  hstat_nxt = ST_UNSUPP;
                  rstat_nxt = ST_UNSUPP;
                end else if (32'(depth_r) >= 32'(MAX_FRAMES)) begin
                  run_nxt   = 1'b0;
                  hstat_nxt = ST_OVERFLOW;
                  rstat_nxt = ST_OVERFLOW;
                end else begin
                  // Return pc goes to word 5 of the frame's row now; the
                  // saved registers follow in the call sequence.
                  fm_we    = 1'b1;
                  fm_waddr = FA'((32'(depth_r) << 3) | 32'd5);
                  fm_wdata = pc_r + 64'd8;
                  cnt_nxt  = '0;
                  st_nxt   = S_CALL;
                end
              end else if (op == JOP_EXIT) begin
                if (depth_r == '0) begin
                  hcode_nxt = rvb[31:0];
                  run_nxt   = 1'b0;
                  hstat_nxt = ST_EXITED;
                  rstat_nxt = ST_EXITED;
                end else begin
                  cnt_nxt = '0;
                  st_nxt  = S_RET;
                end
              end else if (bad_d || (xsrc && bad_s)) begin
                run_nxt   = 1'b0;
                hstat_nxt = ST_UNSUPP;
                rstat_nxt = ST_UNSUPP;
              end else begin
                pc_nxt = pc_r + 64'd8 + (tk ? {off_sx[60:0], 3'b000} : 64'd0);
              end
            end
          endcase
        end
      end

      S_MD: begin
        if (md_rsp.done) begin
          rf_we     = 1'b1;
          valid_nxt = valid_r | (16'(1) << di_r);
          case (op)
            OP_MUL:  rf_wdata = md_prod;
            OP_DIV:  rf_wdata = (md_b == 64'd0) ? 64'd0 : md_quo;
            default: rf_wdata = (md_b == 64'd0) ? md_a : md_rem;
          endcase
          if (!w64) begin
            rf_wdata = {32'd0, rf_wdata[31:0]};
          end
          pc_nxt = pc_r + 64'd8;
          st_nxt = S_OUT;
        end
      end

      S_CALL: begin
        // With cnt_r at n, r(6+n) is read; the word read in the cycle before is saved.
        fm_waddr = FA'((32'(depth_r) << 3) | 32'(cnt_r - 3'd1));
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r != 3'd0) begin
          fm_we = 1'b1;
        end
        if (cnt_r == 3'd5) begin
          rf_we     = 1'b1;
          rf_waddr  = REG_FP;
          rf_wdata  = base_r + 64'(32'(depth_r) + 32'd2) * SB;
          valid_nxt = valid_r | (16'(1) << REG_FP);
          depth_nxt = depth_r + DW'(1);
          pc_nxt    = pc_r + 64'd8 + {imm_sx[60:0], 3'b000};
          st_nxt    = S_OUT;
        end
      end

      S_RET: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r != 3'd0 && cnt_r != 3'd6) begin
          rf_we     = 1'b1;
          rf_waddr  = REG_R6 + {1'b0, cnt_r - 3'd1};
          rf_wdata  = fm_rdata;
          valid_nxt = valid_r | (16'(1) << rf_waddr);
        end
        if (cnt_r == 3'd6) begin
          pc_nxt    = fm_rdata;
          depth_nxt = kdep;
          st_nxt    = S_OUT;
        end
      end

      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt      = 1'b1;
          opc_out_nxt = pc_r;
          oop_nxt     = rop_r;
          oaddr_nxt   = raddr_r;
          obytes_nxt  = rbytes_r;
          odata_nxt   = rdata_r;
          ostat_nxt   = rstat_r;
          ocode_nxt   = (rstat_r == ST_EXITED) ? hcode_r : 32'd0;
          st_nxt      = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      pc_r      <= '0;
      depth_r   <= '0;
      steps_r   <= '0;
      run_r     <= 1'b0;
      ldv_r     <= 1'b0;
      ldreg_r   <= '0;
      ldbytes_r <= '0;
      hstat_r   <= ST_RUN;
      hcode_r   <= '0;
      valid_r   <= '0;
      base_r    <= '0;
      limit_r   <= 32'd10000000;
      ov_r      <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      pc_r      <= pc_nxt;
      depth_r   <= depth_nxt;
      steps_r   <= steps_nxt;
      run_r     <= run_nxt;
      ldv_r     <= ldv_nxt;
      ldreg_r   <= ldreg_nxt;
      ldbytes_r <= ldbytes_nxt;
      hstat_r   <= hstat_nxt;
      hcode_r   <= hcode_nxt;
      valid_r   <= valid_nxt;
      ov_r      <= ov_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[3]) begin
          limit_r <= cfg_pwdata[31:0];
        end else begin
          base_r <= cfg_pwdata;
        end
      end
    end
    if (accept) begin
      cmd_r  <= in_tuser;
      opc_r  <= in_tdata[7:0];
      di_r   <= in_tdata[11:8];
      si_r   <= in_tdata[15:12];
      off_r  <= in_tdata[31:16];
      imm_r  <= in_tdata[63:32];
      nimm_r <= in_tdata[95:64];
      eod_r  <= in_tdata[159:96];
      exit_r <= in_exit;
    end
    va_r      <= valid_r[rf_ra];
    vb_r      <= valid_r[rf_rb];
    rop_r     <= rop_nxt;
    raddr_r   <= raddr_nxt;
    rbytes_r  <= rbytes_nxt;
    rdata_r   <= rdata_nxt;
    rstat_r   <= rstat_nxt;
    opc_out_r <= opc_out_nxt;
    oop_r     <= oop_nxt;
    oaddr_r   <= oaddr_nxt;
    obytes_r  <= obytes_nxt;
    odata_r   <= odata_nxt;
    ostat_r   <= ostat_nxt;
    ocode_r   <= ocode_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'd0, ocode_r, ostat_r, odata_r, obytes_r, oaddr_r, oop_r, opc_out_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[3] ? {32'd0, limit_r} : base_r;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for ebpf_instruction_executor: directed table, then random
// instruction streams per config phase, checked against an in-bench executor model.
// Depends on hdl/ebpf_pkg.sv and hdl/ebpf_instruction_executor.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ebpf_pkg::*;

  localparam int FRAMES = 8;
  localparam int STK = 512;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  opc;
    logic [3:0]  dst;
    logic [3:0]  src;
    logic [15:0] off;
    logic [31:0] imm;
    logic [31:0] nimm;
    logic [63:0] data;
  } insn_t;

  typedef struct packed {
    logic [63:0] pc;
    logic [1:0]  mem_op;
    logic [63:0] addr;
    logic [3:0]  bytes;
    logic [63:0] sdata;
    logic [2:0]  status;
    logic [31:0] code;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [159:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [239:0] out_tdata;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  ebpf_instruction_executor u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Executor model state.
  logic [63:0] gpr[11];
  logic [63:0] pc_m;
  logic [63:0] ret_pc[FRAMES];
  logic [63:0] saved[5*FRAMES];
  int unsigned depth;
  logic [31:0] steps;
  bit running, ld_pend;
  logic [3:0] ld_reg, ld_bytes;
  logic [2:0] halt_st;
  logic [31:0] halt_code;
  logic [63:0] stack_base = '0;
  logic [31:0] step_limit = 32'd10000000;

  res_t exp_q[$];
  int errors = 0, checked = 0, sent = 0, exits = 0, faults = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0, hold_done = 1'b0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] mask_of(logic [3:0] n);
    case (n)
      4'd1: return 64'hff;
      4'd2: return 64'hffff;
      4'd4: return 64'hffff_ffff;
      default: return '1;
    endcase
  endfunction

  function automatic logic [3:0] width_of(logic [1:0] sz);
    case (sz)
      2'b00: return 4'd4;
      2'b01: return 4'd2;
      2'b10: return 4'd1;
      default: return 4'd8;
    endcase
  endfunction

  function automatic logic [63:0] alu_result(logic [3:0] op, logic [63:0] d, logic [63:0] s,
                                             bit w64);
    logic [63:0] r64;
    logic [31:0] r32, d32, s32;
    d32 = d[31:0];
    s32 = s[31:0];
    r64 = d;
    r32 = d32;
    case (op)
      OP_ADD: begin r64 = d + s; r32 = d32 + s32; end
      OP_SUB: begin r64 = d - s; r32 = d32 - s32; end
      OP_MUL: begin r64 = d * s; r32 = d32 * s32; end
      OP_DIV: begin
        r64 = (s == 0) ? 64'd0 : d / s;
        r32 = (s32 == 0) ? 32'd0 : d32 / s32;
      end
      OP_OR:  begin r64 = d | s; r32 = d32 | s32; end
      OP_AND: begin r64 = d & s; r32 = d32 & s32; end
      OP_LSH: begin r64 = d << s[5:0]; r32 = d32 << s32[4:0]; end
      OP_RSH: begin r64 = d >> s[5:0]; r32 = d32 >> s32[4:0]; end
      OP_NEG: begin r64 = 64'd0 - d; r32 = 32'd0 - d32; end
      OP_MOD: begin
        r64 = (s == 0) ? d : d % s;
        r32 = (s32 == 0) ? d32 : d32 % s32;
      end
      OP_XOR: begin r64 = d ^ s; r32 = d32 ^ s32; end
      OP_MOV: begin r64 = s; r32 = s32; end
      OP_ARSH: begin
        r64 = $signed(d) >>> s[5:0];
        r32 = $signed(d32) >>> s32[4:0];
      end
      default: ;
    endcase
    return w64 ? r64 : {32'd0, r32};
  endfunction

  // Signed compares flip the sign bit and then compare unsigned.
  function automatic bit branch_taken(logic [3:0] op, logic [63:0] d, logic [63:0] s,
                                      logic [63:0] sb);
    logic [63:0] sd, ss;
    sd = d ^ sb;
    ss = s ^ sb;
    case (op)
      JOP_JA:   return 1'b1;
      JOP_JEQ:  return d == s;
      JOP_JGT:  return d > s;
      JOP_JGE:  return d >= s;
      JOP_JSET: return (d & s) != 0;
      JOP_JNE:  return d != s;
      JOP_JSGT: return sd > ss;
      JOP_JSGE: return sd >= ss;
      JOP_JLT:  return d < s;
      JOP_JLE:  return d <= s;
      JOP_JSLT: return sd < ss;
      JOP_JSLE: return sd <= ss;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic res_t report_out(logic [1:0] mop, logic [63:0] a, logic [3:0] n,
                                      logic [63:0] v, logic [2:0] st);
    res_t r;
    r.pc = pc_m;
    r.mem_op = mop;
    r.addr = a;
    r.bytes = n;
    r.sdata = v;
    r.status = st;
    r.code = (st == ST_EXITED) ? halt_code : 32'd0;
    return r;
  endfunction

  function automatic res_t stop_run(logic [2:0] st);
    running = 1'b0;
    halt_st = st;
    faults += (st != ST_EXITED);
    return report_out(MEM_NONE, 0, 0, 0, st);
  endfunction

  function automatic res_t execute(insn_t it);
    logic [2:0] cls;
    logic [3:0] op, n;
    bit xs;
    logic [63:0] off64, imm64, s, d, sb, nxt;
    int unsigned k;
    cls = it.opc[2:0];
    op = it.opc[7:4];
    xs = it.opc[3];
    off64 = {{48{it.off[15]}}, it.off};
    imm64 = {{32{it.imm[31]}}, it.imm};
    if (it.cmd == CMD_START) begin
      foreach (gpr[i]) gpr[i] = '0;
      pc_m = it.data;
      gpr[10] = stack_base + STK;
      running = 1'b1;
      depth = 0;
      steps = '0;
      ld_pend = 1'b0;
      halt_st = ST_RUN;
      halt_code = '0;
      return report_out(MEM_NONE, 0, 0, 0, ST_RUN);
    end
    if (!running || it.cmd == CMD_NONE)
      return report_out(MEM_NONE, 0, 0, 0, running ? ST_RUN : halt_st);
    if (it.cmd == CMD_LOAD) begin
      if (ld_pend) begin
        gpr[ld_reg] = it.data & mask_of(ld_bytes);
        ld_pend = 1'b0;
      end
      return report_out(MEM_NONE, 0, 0, 0, ST_RUN);
    end
    if (ld_pend) return report_out(MEM_NONE, 0, 0, 0, ST_RUN);
    if (steps >= step_limit) return stop_run(ST_STEPLIMIT);
    steps++;
    n = width_of(it.opc[4:3]);
    case (cls)
      CLS_ALU, CLS_ALU64: begin
        if (it.dst > 10 || (xs && it.src > 10)) return stop_run(ST_UNSUPP);
        gpr[it.dst] = alu_result(op, gpr[it.dst], xs ? gpr[it.src] : imm64, cls == CLS_ALU64);
        pc_m += 8;
        return report_out(MEM_NONE, 0, 0, 0, ST_RUN);
      end
      CLS_LDX: begin
        if (it.dst > 10 || it.src > 10) return stop_run(ST_UNSUPP);
        ld_pend = 1'b1;
        ld_reg = it.dst;
        ld_bytes = n;
        pc_m += 8;
        return report_out(MEM_READ, gpr[it.src] + off64, n, 0, ST_RUN);
      end
      CLS_ST, CLS_STX: begin
        if (it.dst > 10 || (cls == CLS_STX && it.src > 10)) return stop_run(ST_UNSUPP);
        s = (cls == CLS_STX) ? gpr[it.src] : imm64;
        pc_m += 8;
        return report_out(MEM_WRITE, gpr[it.dst] + off64, n, s & mask_of(n), ST_RUN);
      end
      CLS_LD: begin
        if (it.opc != OPC_LDDW || it.dst > 10) return stop_run(ST_UNSUPP);
        gpr[it.dst] = {it.nimm, it.imm};
        pc_m += 16;
        return report_out(MEM_NONE, 0, 0, 0, ST_RUN);
      end
      default: ;
    endcase
    if (op == JOP_CALL) begin
      nxt = pc_m + 8;
      k = depth;
      if (it.src != 4'd1) return stop_run(ST_UNSUPP);
      if (k >= FRAMES) return stop_run(ST_OVERFLOW);
      ret_pc[k] = nxt;
      for (int i = 0; i < 5; i++) saved[k*5+i] = gpr[6+i];
      depth = k + 1;
      gpr[10] = stack_base + 64'(k + 2) * STK;
      pc_m = nxt + {imm64[60:0], 3'b000};
      return report_out(MEM_NONE, 0, 0, 0, ST_RUN);
    end
    if (op == JOP_EXIT) begin
      if (depth == 0) begin
        halt_code = gpr[0][31:0];
        exits++;
        return stop_run(ST_EXITED);
      end
      depth--;
      pc_m = ret_pc[depth];
      for (int i = 0; i < 5; i++) gpr[6+i] = saved[depth*5+i];
      return report_out(MEM_NONE, 0, 0, 0, ST_RUN);
    end
    if (it.dst > 10 || (xs && it.src > 10)) return stop_run(ST_UNSUPP);
    s = xs ? gpr[it.src] : imm64;
    d = gpr[it.dst];
    sb = 64'h8000_0000_0000_0000;
    if (cls == CLS_JMP32) begin
      s &= 64'hffff_ffff;
      d &= 64'hffff_ffff;
      sb = 64'h8000_0000;
    end
    pc_m += 8;
    if (branch_taken(op, d, s, sb)) pc_m += {off64[60:0], 3'b000};
    return report_out(MEM_NONE, 0, 0, 0, ST_RUN);
  endfunction

  function automatic insn_t mk(logic [1:0] cmd, logic [7:0] opc, logic [3:0] dst,
                               logic [3:0] src, logic [15:0] off, logic [31:0] imm,
                               logic [31:0] nimm, logic [63:0] data);
    insn_t it;
    it = '{cmd, opc, dst, src, off, imm, nimm, data};
    return it;
  endfunction

  task automatic send(insn_t it, bit typed, res_t known);
    res_t p;
    p = execute(it);
    exp_q.push_back(typed ? known : p);
    if (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.cmd;
    in_tdata <= {it.data, it.nimm, it.imm, it.off, it.src, it.dst, it.opc};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic drain(int extra);
    in_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic reg_write(logic [3:0] addr, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == 4'd0) stack_base = val;
    else step_limit = val[31:0];
  endtask

  function automatic logic [3:0] pick_reg();
    return ($urandom_range(99) < 3) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
  endfunction

  function automatic logic [31:0] pick_imm();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4, 5: return 32'($urandom_range(70));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed programs: start a run, feed back load data, end with exit.
  function automatic insn_t rand_item();
    insn_t it;
    int r;
    logic [3:0] jop;
    it = '{cmd: CMD_EXEC, opc: 8'h0, dst: pick_reg(), src: pick_reg(),
           off: 16'($urandom_range(0, 10) - 3), imm: pick_imm(), nimm: $urandom,
           data: rand64()};
    r = $urandom_range(99);
    if (!running) begin
      if (r < 85) begin
        it.cmd = CMD_START;
        if ($urandom_range(9) == 0) it.data = rand64();
        else it.data = {48'd0, 13'($urandom), 3'b000};
      end else it.cmd = 2'($urandom_range(1, 3));
      return it;
    end
    if (ld_pend) begin
      if (r < 90) it.cmd = CMD_LOAD;
      else it.cmd = (r < 95) ? CMD_EXEC : CMD_NONE;
      return it;
    end
    if (r < 1) it.cmd = CMD_START;
    else if (r < 2) it.cmd = CMD_NONE;
    else if (r < 3) it.cmd = CMD_LOAD;
    if ($urandom_range(15) == 0) it.off = $urandom;
    r = $urandom_range(99);
    if (r < 35) begin
      it.opc = {4'($urandom_range(15)), 1'($urandom), $urandom_range(1) ? CLS_ALU64 : CLS_ALU};
    end else if (r < 50) begin
      do jop = 4'($urandom_range(15)); while (jop == JOP_CALL || jop == JOP_EXIT);
      it.opc = {jop, 1'($urandom), $urandom_range(1) ? CLS_JMP : CLS_JMP32};
    end else if (r < 57) begin
      it.opc = {JOP_CALL, 1'b0, CLS_JMP};
      it.src = ($urandom_range(19) == 0) ? 4'($urandom) : 4'd1;
      it.imm = 32'($urandom_range(0, 6) - 2);
    end else if (r < 64) begin
      it.opc = {JOP_EXIT, 1'($urandom), CLS_JMP};
    end else if (r < 73) begin
      it.opc = {3'($urandom), 2'($urandom), CLS_LDX};
    end else if (r < 83) begin
      it.opc = {3'($urandom), 2'($urandom), $urandom_range(1) ? CLS_STX : CLS_ST};
    end else if (r < 91) begin
      it.opc = OPC_LDDW;
    end else if (r < 94) begin
      do it.opc = {5'($urandom), CLS_LD}; while (it.opc == OPC_LDDW);
    end else begin
      it.opc = $urandom;
    end
    return it;
  endfunction

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on result %0d, %s: expected %h, got %h", checked, name, e, a);
    end
  endtask

  // Result side: random stalls plus one long hold-off when asked.
  always @(posedge clk) begin
    res_t e, a;
    if (rst_n && out_tvalid && out_tready) begin
      // Result fields sit in tdata from the lowest bit up.
      a.pc     = out_tdata[63:0];
      a.mem_op = out_tdata[65:64];
      a.addr   = out_tdata[129:66];
      a.bytes  = out_tdata[133:130];
      a.sdata  = out_tdata[197:134];
      a.status = out_tdata[200:198];
      a.code   = out_tdata[232:201];
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result item with nothing expected: %h", out_tdata);
      end else begin
        e = exp_q.pop_front();
        check_field("pc", e.pc, a.pc);
        check_field("mem_op", 64'(e.mem_op), 64'(a.mem_op));
        check_field("mem_addr", e.addr, a.addr);
        check_field("mem_bytes", 64'(e.bytes), 64'(a.bytes));
        check_field("store_data", e.sdata, a.sdata);
        check_field("status", 64'(e.status), 64'(a.status));
        check_field("exit_value", 64'(e.code), 64'(a.code));
      end
      checked++;
    end
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 250;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    insn_t dir_rows[$];
    bit dir_typed[$];
    res_t dir_res[$];
    res_t none;
    none = '0;
    pc_m = '0;
    foreach (gpr[i]) gpr[i] = '0;
    depth = 0;
    steps = '0;
    running = 1'b0;
    ld_pend = 1'b0;
    halt_st = ST_RUN;
    halt_code = '0;

    // Rows with a typed result carry it; the rest rely on the model.
    dir_rows.push_back(mk(CMD_EXEC, 8'hb7, 1, 0, 0, 5, 0, 0));
    dir_typed.push_back(1); dir_res.push_back('{64'd0, MEM_NONE, 0, 0, 0, ST_RUN, 0});
    dir_rows.push_back(mk(CMD_START, 0, 0, 0, 0, 0, 0, 64'h40));
    dir_typed.push_back(1); dir_res.push_back('{64'h40, MEM_NONE, 0, 0, 0, ST_RUN, 0});
    dir_rows.push_back(mk(CMD_EXEC, 8'h00, 1, 0, 0, 0, 0, 0));
    dir_typed.push_back(1); dir_res.push_back('{64'h40, MEM_NONE, 0, 0, 0, ST_UNSUPP, 0});
    dir_rows.push_back(mk(CMD_EXEC, 8'hb7, 1, 0, 0, 5, 0, 0));
    dir_typed.push_back(1); dir_res.push_back('{64'h40, MEM_NONE, 0, 0, 0, ST_UNSUPP, 0});
    dir_rows.push_back(mk(CMD_NONE, 8'hff, 15, 15, 16'hffff, '1, '1, '1));
    dir_typed.push_back(1); dir_res.push_back('{64'h40, MEM_NONE, 0, 0, 0, ST_UNSUPP, 0});
    dir_rows.push_back(mk(CMD_START, 0, 0, 0, 0, 0, 0, 64'h1000));
    dir_typed.push_back(1); dir_res.push_back('{64'h1000, MEM_NONE, 0, 0, 0, ST_RUN, 0});
    dir_rows.push_back(mk(CMD_EXEC, 8'h07, 15, 0, 0, 1, 0, 0));
    dir_typed.push_back(1); dir_res.push_back('{64'h1000, MEM_NONE, 0, 0, 0, ST_UNSUPP, 0});
    dir_rows.push_back(mk(CMD_START, 0, 0, 0, 0, 0, 0, '1));
    dir_rows.push_back(mk(CMD_EXEC, 8'hb7, 1, 0, 0, 32'hffff_ffff, 0, 0));
    dir_rows.push_back(mk(CMD_EXEC, OPC_LDDW, 2, 0, 0, 32'h89ab_cdef, 32'h0123_4567, 0));
    dir_rows.push_back(mk(CMD_EXEC, 8'h37, 2, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CMD_EXEC, 8'h9f, 1, 3, 0, 0, 0, 0));
    dir_rows.push_back(mk(CMD_EXEC, 8'hc4, 1, 0, 0, 31, 0, 0));
    dir_rows.push_back(mk(CMD_EXEC, 8'h87, 2, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(CMD_EXEC, 8'h7b, 10, 1, 16'h8000, 0, 0, 0));
    dir_rows.push_back(mk(CMD_EXEC, 8'h72, 10, 0, 16'h7fff, 32'h8000_0000, 0, 0));
    dir_rows.push_back(mk(CMD_EXEC, 8'h61, 4, 10, 16'hfff8, 0, 0, 0));
    dir_rows.push_back(mk(CMD_EXEC, 8'hb7, 4, 0, 0, 1, 0, 0));
    dir_rows.push_back(mk(CMD_LOAD, 0, 0, 0, 0, 0, 0, '1));
    dir_rows.push_back(mk(CMD_EXEC, 8'h66, 1, 0, 5, 0, 0, 0));
    dir_rows.push_back(mk(CMD_EXEC, 8'h85, 0, 0, 0, 2, 0, 0));
    for (int i = 0; i < 9; i++) dir_rows.push_back(mk(CMD_EXEC, 8'h85, 0, 1, 0, '1, 0, 0));
    while (dir_typed.size() < dir_rows.size()) begin
      dir_typed.push_back(0);
      dir_res.push_back(none);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send(dir_rows[i], dir_typed[i], dir_res[i]);
    // Normal exit path: call, return, set r0, exit at the outer frame.
    send(mk(CMD_START, 0, 0, 0, 0, 0, 0, 64'h800), 0, none);
    send(mk(CMD_EXEC, 8'hb7, 6, 0, 0, 32'h1234, 0, 0), 0, none);
    send(mk(CMD_EXEC, 8'h85, 0, 1, 0, 4, 0, 0), 0, none);
    send(mk(CMD_EXEC, 8'hb7, 6, 0, 0, 0, 0, 0), 0, none);
    send(mk(CMD_EXEC, 8'h95, 0, 0, 0, 0, 0, 0), 0, none);
    send(mk(CMD_EXEC, 8'hb7, 0, 0, 0, 32'h8000_0001, 0, 0), 0, none);
    send(mk(CMD_EXEC, 8'h95, 0, 0, 0, 0, 0, 0), 0, none);

    for (int ph = 1; ph <= 4; ph++) begin
      int count;
      drain(80);
      case (ph)
        1: begin
          reg_write(4'd0, 64'hffff_ffff_ffff_fe00);
          reg_write(4'd8, 32'hffff_ffff);
          count = 300;
        end
        2: begin
          reg_write(4'd0, rand64());
          reg_write(4'd8, 32'd1);
          count = 120;
        end
        3: begin
          reg_write(4'd0, 64'd0);
          reg_write(4'd8, 32'd25);
          count = 250;
        end
        default: begin
          reg_write(4'd0, rand64());
          reg_write(4'd8, 32'd10000000);
          count = 280;
        end
      endcase
      for (int i = 0; i < count; i++) begin
        if (ph == 1 && i == 40) hold_req = 1'b1;
        if (ph == 3 && i == 60) calm = 1'b1;
        if (ph == 3 && i == 180) calm = 1'b0;
        if (ph == 3 && i == 125) drain(0);
        send(rand_item(), 0, none);
      end
    end

    drain(150);
    $display("Sent %0d items and checked %0d results over five config settings.", sent, checked);
    $display("Runs ended by exit: %0d, by fault or limit halts: %0d.", exits, faults);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
